// ===== rtl/core/afg_pkg.sv =====
package afg_pkg;

   localparam int TIME_W  = 32;
   localparam int MS_W    = 16;
   localparam int GAIN_W  = 17;
   localparam int OP_W    = 3;
   localparam int ACT_W   = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   // divider: 32-bit numerator shifted up by 16, quotient of 48 bits
   localparam int FRAC_W          = 16;
   localparam int QUO_W           = TIME_W + FRAC_W;
   localparam int DIV_LONG_STEPS  = QUO_W;
   localparam int DIV_SHORT_STEPS = FRAC_W;
   localparam int DIV_CNT_W       = $clog2(DIV_LONG_STEPS + 1);

   // multiplier: 17-bit gain times a ratio of up to 2^33
   localparam int MUL_B_W = 34;
   localparam int MUL_P_W = GAIN_W + MUL_B_W;

   localparam logic [GAIN_W-1:0]  Q_ONE     = 17'h1_0000;
   localparam logic [MUL_B_W-1:0] RATIO_CAP = 34'h2_0000_0000;

   localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
   localparam logic [OP_W-1:0] OP_RESUME = 3'd1;
   localparam logic [OP_W-1:0] OP_PAUSE  = 3'd2;
   localparam logic [OP_W-1:0] OP_STOP   = 3'd3;
   localparam logic [OP_W-1:0] OP_MUTE   = 3'd4;
   localparam logic [OP_W-1:0] OP_UNMUTE = 3'd5;

   localparam logic [ACT_W-1:0] ACT_PAUSE = 2'd0;
   localparam logic [ACT_W-1:0] ACT_STOP  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_MUTE  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_INTRO  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OUTRO  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LENGTH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MASTER = 2'd3;

   typedef struct packed {
      logic start;
      logic long_div;
   } div_ctl_type;

   // product >> 16, held at 1.0
   function automatic logic [GAIN_W-1:0] sat_q16(input logic [MUL_P_W-1:0] prod);
      logic [MUL_P_W-FRAC_W-1:0] q;
      q = prod[MUL_P_W-1:FRAC_W];
      if (q > {{(MUL_P_W-FRAC_W-GAIN_W){1'b0}}, Q_ONE})
         return Q_ONE;
      else
         return q[GAIN_W-1:0];
   endfunction

endpackage

// ===== rtl/core/afg_div.sv =====
module afg_div (
   input  logic                         clock,
   input  logic                         reset,
   input  afg_pkg::div_ctl_type         ctl,
   input  logic [afg_pkg::TIME_W-1:0]   num,
   input  logic [afg_pkg::TIME_W-1:0]   den,
   output logic                         done,
   output logic [afg_pkg::QUO_W-1:0]    quo
);
   import afg_pkg::*;

   logic [TIME_W-1:0]    rem_ff, rem_in;
   logic [QUO_W-1:0]     dvd_ff, dvd_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic [TIME_W-1:0]    den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [TIME_W:0]      trial;
   logic [TIME_W:0]      diff;
   logic                 ge;

   assign trial = {rem_ff, dvd_ff[QUO_W-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         den_in  = den;
         quo_in  = '0;
         busy_in = 1'b1;
         if (ctl.long_div) begin
            rem_in = '0;
            dvd_in = {num, {FRAC_W{1'b0}}};
            cnt_in = DIV_CNT_W'(DIV_LONG_STEPS);
         end else begin
            // numerator below divisor: integer bits are all zero
            rem_in = num;
            dvd_in = '0;
            cnt_in = DIV_CNT_W'(DIV_SHORT_STEPS);
         end
      end else if (busy_ff) begin
         rem_in = ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
         dvd_in = {dvd_ff[QUO_W-2:0], 1'b0};
         quo_in = {quo_ff[QUO_W-2:0], ge};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== rtl/core/afg_mul.sv =====
module afg_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [afg_pkg::GAIN_W-1:0]    op_a,
   input  logic [afg_pkg::MUL_B_W-1:0]   op_b,
   output logic                          done,
   output logic [afg_pkg::MUL_P_W-1:0]   prod
);
   import afg_pkg::*;

   logic [MUL_P_W-1:0] acc_ff, acc_in;
   logic [MUL_P_W-1:0] mc_ff, mc_in;
   logic [MUL_B_W-1:0] mp_ff, mp_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   // one multiplier bit per cycle, stops when no set bits remain
   always_comb begin
      acc_in  = acc_ff;
      mc_in   = mc_ff;
      mp_in   = mp_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         mc_in   = {{(MUL_P_W-GAIN_W){1'b0}}, op_a};
         mp_in   = op_b;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mp_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (mp_ff[0])
               acc_in = acc_ff + mc_ff;
            mc_in = {mc_ff[MUL_P_W-2:0], 1'b0};
            mp_in = {1'b0, mp_ff[MUL_B_W-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

// ===== rtl/core/audio_fade_gain_envelope.sv =====
// Linear volume fade envelope for one playback channel. Each input item is a
// millisecond tick or a command (resume, pause, stop or mute, each with an
// optional fade, or unmute) and yields exactly one result: gain in Q1.16
// (65536 = full scale) with paused, stopped and muted flags. Configuration
// registers are written through the csr_ port; the user must write them only
// while no item is in flight, as the block itself does not enforce this.
// Items are processed one at a time; req_stall is high from acceptance until
// the result is handed to the output register, which can still hold the
// previous result meanwhile. The item time is set by a radix-2 serial divider
// (16 steps, 48 for a ramp-in past its span) and a shift-add multiplier (one
// cycle per multiplier bit up to its top set bit). A paused or muted item
// skips both units; a tick with no fade active uses only the master multiply.
module audio_fade_gain_envelope (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [afg_pkg::OP_W-1:0]          req_opcode,
   input  logic [afg_pkg::TIME_W-1:0]        req_play_time,
   input  logic [afg_pkg::TIME_W-1:0]        req_track_time,
   input  logic [afg_pkg::MS_W-1:0]          req_fade_ms,
   input  logic                              req_last_loop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [afg_pkg::GAIN_W-1:0]        rsp_gain,
   output logic                              rsp_is_paused,
   output logic                              rsp_is_stopped,
   output logic                              rsp_is_muted,
   input  logic                              csr_wr_en,
   input  logic [afg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [afg_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import afg_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_PREP   = 4'd1;
   localparam logic [3:0] S_DIVB   = 4'd2;
   localparam logic [3:0] S_RAMP   = 4'd3;
   localparam logic [3:0] S_DIVR   = 4'd4;
   localparam logic [3:0] S_MULR   = 4'd5;
   localparam logic [3:0] S_MSTART = 4'd6;
   localparam logic [3:0] S_MAST   = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   logic [3:0]        state_ff, state_in;

   logic [MS_W-1:0]   intro_ff, intro_in;
   logic [MS_W-1:0]   outro_ff, outro_in;
   logic [TIME_W-1:0] tlen_ff, tlen_in;
   logic [GAIN_W-1:0] master_ff, master_in;

   logic [TIME_W-1:0] rin_start_ff, rin_start_in;
   logic [TIME_W-1:0] rin_end_ff, rin_end_in;
   logic [TIME_W-1:0] rout_start_ff, rout_start_in;
   logic [TIME_W-1:0] rout_end_ff, rout_end_in;
   logic [ACT_W-1:0]  act_ff, act_in;
   logic              silent_ff, silent_in;
   logic              paused_ff, paused_in;
   logic              stopped_ff, stopped_in;
   logic              intro_pend_ff, intro_pend_in;

   logic [TIME_W-1:0] pos_ff, pos_in;
   logic [TIME_W-1:0] opos_ff, opos_in;
   logic              last_ff, last_in;
   logic [GAIN_W-1:0] vol_ff, vol_in;
   logic [GAIN_W-1:0] res_ff, res_in;
   logic              upd_ff, upd_in;
   logic              base_intro_ff, base_intro_in;
   logic              rsel_in_ff, rsel_in_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [GAIN_W-1:0] rsp_gain_ff, rsp_gain_in;
   logic              rsp_paused_ff, rsp_paused_in;
   logic              rsp_stopped_ff, rsp_stopped_in;
   logic              rsp_muted_ff, rsp_muted_in;

   div_ctl_type         div_ctl;
   logic [TIME_W-1:0]   div_num;
   logic [TIME_W-1:0]   div_den;
   logic                div_done;
   logic [QUO_W-1:0]    div_quo;
   logic                mul_start;
   logic [MUL_B_W-1:0]  mul_b;
   logic                mul_done;
   logic [MUL_P_W-1:0]  mul_prod;

   logic                intro_on;
   logic                any_fade;
   logic [TIME_W+1:0]   dsum;
   logic                d_pos;
   logic                rin_act;
   logic [TIME_W-1:0]   rin_num;
   logic [TIME_W-1:0]   rin_den;
   logic                rout_act;
   logic [TIME_W-1:0]   rout_num;
   logic [TIME_W-1:0]   rout_den;
   logic [MUL_B_W-1:0]  ratio_r;
   logic [GAIN_W-1:0]   quo_frac;

   afg_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   afg_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .op_a  (vol_ff),
      .op_b  (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   assign intro_on = intro_pend_ff && (intro_ff != '0);
   assign any_fade = intro_on || (outro_ff != '0) || (rin_start_ff != '0)
                     || (rout_start_ff != '0);
   // track_time + outro - length, signed
   assign dsum  = {2'b00, opos_ff} + {{(TIME_W+2-MS_W){1'b0}}, outro_ff}
                  - {2'b00, tlen_ff};
   assign d_pos = !dsum[TIME_W+1] && (dsum != '0);

   assign rin_act  = (rin_start_ff != '0) && (pos_ff < rin_end_ff);
   assign rin_num  = pos_ff - rin_start_ff;
   assign rin_den  = rin_end_ff - rin_start_ff;
   assign rout_act = (rout_start_ff != '0) && (pos_ff > rout_start_ff);
   assign rout_num = pos_ff - rout_start_ff;
   assign rout_den = rout_end_ff - rout_start_ff;

   assign ratio_r  = (div_quo > {{(QUO_W-MUL_B_W){1'b0}}, RATIO_CAP}) ? RATIO_CAP
                     : div_quo[MUL_B_W-1:0];
   assign quo_frac = div_quo[GAIN_W-1:0];

   always_comb begin
      state_in       = state_ff;
      intro_in       = intro_ff;
      outro_in       = outro_ff;
      tlen_in        = tlen_ff;
      master_in      = master_ff;
      rin_start_in   = rin_start_ff;
      rin_end_in     = rin_end_ff;
      rout_start_in  = rout_start_ff;
      rout_end_in    = rout_end_ff;
      act_in         = act_ff;
      silent_in      = silent_ff;
      paused_in      = paused_ff;
      stopped_in     = stopped_ff;
      intro_pend_in  = intro_pend_ff;
      pos_in         = pos_ff;
      opos_in        = opos_ff;
      last_in        = last_ff;
      vol_in         = vol_ff;
      res_in         = res_ff;
      upd_in         = upd_ff;
      base_intro_in  = base_intro_ff;
      rsel_in_in     = rsel_in_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_gain_in    = rsp_gain_ff;
      rsp_paused_in  = rsp_paused_ff;
      rsp_stopped_in = rsp_stopped_ff;
      rsp_muted_in   = rsp_muted_ff;
      div_ctl        = '0;
      div_num        = '0;
      div_den        = '0;
      mul_start      = 1'b0;
      mul_b          = {{(MUL_B_W-GAIN_W){1'b0}}, master_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pos_in   = req_play_time;
               opos_in  = req_track_time;
               last_in  = req_last_loop;
               state_in = S_PREP;
               unique case (req_opcode) inside
                  OP_RESUME: begin
                     if (req_fade_ms != '0) begin
                        rin_start_in = req_play_time;
                        rin_end_in   = req_play_time
                                       + {{(TIME_W-MS_W){1'b0}}, req_fade_ms};
                     end
                     paused_in  = 1'b0;
                     stopped_in = 1'b0;
                  end
                  OP_PAUSE, OP_STOP: begin
                     if (req_fade_ms == '0) begin
                        paused_in     = 1'b1;
                        stopped_in    = (req_opcode == OP_STOP) ? 1'b1 : stopped_ff;
                        rout_start_in = '0;
                        rout_end_in   = '0;
                        act_in        = ACT_MUTE;
                     end else begin
                        rout_start_in = req_play_time;
                        rout_end_in   = req_play_time
                                        + {{(TIME_W-MS_W){1'b0}}, req_fade_ms};
                        act_in        = (req_opcode == OP_STOP) ? ACT_STOP : ACT_PAUSE;
                     end
                  end
                  OP_MUTE: begin
                     if (req_fade_ms == '0) begin
                        silent_in = 1'b1;
                     end else begin
                        rout_start_in = req_play_time;
                        rout_end_in   = req_play_time
                                        + {{(TIME_W-MS_W){1'b0}}, req_fade_ms};
                        act_in        = ACT_MUTE;
                     end
                  end
                  OP_UNMUTE: begin
                     silent_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_PREP: begin
            if (paused_ff) begin
               upd_in   = 1'b0;
               res_in   = '0;
               state_in = S_DONE;
            end else if (silent_ff) begin
               upd_in   = 1'b1;
               res_in   = '0;
               state_in = S_DONE;
            end else if (!any_fade) begin
               upd_in   = 1'b1;
               vol_in   = Q_ONE;
               state_in = S_RAMP;
            end else begin
               upd_in = 1'b1;
               if (pos_ff >= rin_end_ff) begin
                  rin_start_in = '0;
                  rin_end_in   = '0;
               end
               if (intro_on && (pos_ff < {{(TIME_W-MS_W){1'b0}}, intro_ff})) begin
                  div_ctl.start = 1'b1;
                  div_num       = pos_ff;
                  div_den       = {{(TIME_W-MS_W){1'b0}}, intro_ff};
                  base_intro_in = 1'b1;
                  state_in      = S_DIVB;
               end else if ((outro_ff != '0) && d_pos && last_ff) begin
                  if (dsum[TIME_W:0] >= {{(TIME_W+1-MS_W){1'b0}}, outro_ff}) begin
                     vol_in   = '0;
                     state_in = S_RAMP;
                  end else begin
                     div_ctl.start = 1'b1;
                     div_num       = dsum[TIME_W-1:0];
                     div_den       = {{(TIME_W-MS_W){1'b0}}, outro_ff};
                     base_intro_in = 1'b0;
                     state_in      = S_DIVB;
                  end
               end else begin
                  vol_in   = Q_ONE;
                  state_in = S_RAMP;
               end
            end
         end
         S_DIVB: begin
            if (div_done) begin
               vol_in   = base_intro_ff ? quo_frac : Q_ONE - quo_frac;
               state_in = S_RAMP;
            end
         end
         S_RAMP: begin
            if (rin_act) begin
               rsel_in_in = 1'b1;
               if (rin_num >= rin_den) begin
                  if (rin_den == '0) begin
                     // ratio of exactly one leaves the gain as is
                     state_in = S_MSTART;
                  end else begin
                     div_ctl.start    = 1'b1;
                     div_ctl.long_div = 1'b1;
                     div_num          = rin_num;
                     div_den          = rin_den;
                     state_in         = S_DIVR;
                  end
               end else begin
                  div_ctl.start = 1'b1;
                  div_num       = rin_num;
                  div_den       = rin_den;
                  state_in      = S_DIVR;
               end
            end else if (rout_act) begin
               rsel_in_in = 1'b0;
               if (rout_num >= rout_den) begin
                  res_in   = '0;
                  state_in = S_DONE;
               end else begin
                  div_ctl.start = 1'b1;
                  div_num       = rout_num;
                  div_den       = rout_den;
                  state_in      = S_DIVR;
               end
               if (pos_ff > rout_end_ff) begin
                  rout_start_in = '0;
                  rout_end_in   = '0;
                  if (act_ff < ACT_MUTE) begin
                     // pause or stop ends in silence this item
                     paused_in  = 1'b1;
                     stopped_in = (act_ff == ACT_STOP) ? 1'b1 : stopped_ff;
                     act_in     = ACT_MUTE;
                     res_in     = '0;
                     div_ctl    = '0;
                     state_in   = S_DONE;
                  end else begin
                     silent_in = 1'b1;
                  end
               end
            end else begin
               state_in = S_MSTART;
            end
         end
         S_DIVR: begin
            if (div_done) begin
               mul_start = 1'b1;
               mul_b     = rsel_in_ff ? ratio_r
                           : {{(MUL_B_W-GAIN_W){1'b0}}, Q_ONE - quo_frac};
               state_in  = S_MULR;
            end
         end
         S_MULR: begin
            if (mul_done) begin
               vol_in   = sat_q16(mul_prod);
               state_in = S_MSTART;
            end
         end
         S_MSTART: begin
            mul_start = 1'b1;
            state_in  = S_MAST;
         end
         S_MAST: begin
            if (mul_done) begin
               res_in   = sat_q16(mul_prod);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_gain_in    = paused_ff ? '0 : res_ff;
               rsp_paused_in  = paused_ff;
               rsp_stopped_in = stopped_ff;
               rsp_muted_in   = silent_ff || ((rout_start_ff != '0) && (act_ff >= ACT_MUTE));
               if (upd_ff && !stopped_ff && intro_on
                   && (pos_ff > {{(TIME_W-MS_W){1'b0}}, intro_ff}))
                  intro_pend_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         unique case (csr_index)
            REG_INTRO:  intro_in = csr_wdata[MS_W-1:0];
            REG_OUTRO:  outro_in = csr_wdata[MS_W-1:0];
            REG_LENGTH: tlen_in  = csr_wdata[TIME_W-1:0];
            REG_MASTER: master_in = (csr_wdata[GAIN_W-1:0] > Q_ONE) ? Q_ONE
                                    : csr_wdata[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      opos_ff        <= opos_in;
      last_ff        <= last_in;
      vol_ff         <= vol_in;
      res_ff         <= res_in;
      upd_ff         <= upd_in;
      base_intro_ff  <= base_intro_in;
      rsel_in_ff     <= rsel_in_in;
      rsp_gain_ff    <= rsp_gain_in;
      rsp_paused_ff  <= rsp_paused_in;
      rsp_stopped_ff <= rsp_stopped_in;
      rsp_muted_ff   <= rsp_muted_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         intro_ff      <= '0;
         outro_ff      <= '0;
         tlen_ff       <= '0;
         master_ff     <= Q_ONE;
         rin_start_ff  <= '0;
         rin_end_ff    <= '0;
         rout_start_ff <= '0;
         rout_end_ff   <= '0;
         act_ff        <= ACT_PAUSE;
         silent_ff     <= 1'b0;
         paused_ff     <= 1'b0;
         stopped_ff    <= 1'b0;
         intro_pend_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         intro_ff      <= intro_in;
         outro_ff      <= outro_in;
         tlen_ff       <= tlen_in;
         master_ff     <= master_in;
         rin_start_ff  <= rin_start_in;
         rin_end_ff    <= rin_end_in;
         rout_start_ff <= rout_start_in;
         rout_end_ff   <= rout_end_in;
         act_ff        <= act_in;
         silent_ff     <= silent_in;
         paused_ff     <= paused_in;
         stopped_ff    <= stopped_in;
         intro_pend_ff <= intro_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_gain       = rsp_gain_ff;
   assign rsp_is_paused  = rsp_paused_ff;
   assign rsp_is_stopped = rsp_stopped_ff;
   assign rsp_is_muted   = rsp_muted_ff;

endmodule

// ===== sim/afg_gain_checker.sv =====
`timescale 1ns / 100ps

module afg_gain_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [afg_pkg::OP_W-1:0]       req_opcode,
   input  logic [afg_pkg::TIME_W-1:0]     req_play_time,
   input  logic [afg_pkg::TIME_W-1:0]     req_track_time,
   input  logic [afg_pkg::MS_W-1:0]       req_fade_ms,
   input  logic                           req_last_loop,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [afg_pkg::GAIN_W-1:0]     rsp_gain,
   input  logic                           rsp_is_paused,
   input  logic                           rsp_is_stopped,
   input  logic                           rsp_is_muted,
   input  logic                           csr_wr_en,
   input  logic [afg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [afg_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             fail_count,
   output int                             open_count
);
   import afg_pkg::*;

   localparam logic [63:0] UNITY = 64'd65536;

   typedef struct packed {
      logic [GAIN_W-1:0] gain;
      logic              paused;
      logic              stopped;
      logic              muted;
   } env_out_type;

   logic [31:0]       cfg_intro, cfg_outro, cfg_len;
   logic [GAIN_W-1:0] cfg_master;
   logic [31:0]       rin_t0, rin_t1, rout_t0, rout_t1;
   logic [ACT_W-1:0]  pend_act;
   bit                hush, held, halted, intro_armed;

   env_out_type gain_q[$];
   env_out_type want;
   int          fails;
   int          rsp_seen;

   function automatic logic [63:0] q16_ratio(logic [63:0] num, logic [63:0] den,
                                             logic [63:0] cap);
      logic [63:0] r;
      if (den == 0)
         return (cap < UNITY) ? cap : UNITY;
      r = (num << 16) / den;
      return (r > cap) ? cap : r;
   endfunction

   function automatic void clear_fade_out();
      rout_t0 = '0;
      rout_t1 = '0;
      pend_act = ACT_MUTE;
   endfunction

   function automatic void arm_fade_out(logic [31:0] at, logic [15:0] span,
                                        logic [ACT_W-1:0] act);
      rout_t0 = at;
      rout_t1 = at + 32'(span);
      pend_act = act;
   endfunction

   // fade envelope before master scaling
   function automatic logic [63:0] envelope_gain(logic [31:0] ms_now, logic [31:0] tpos,
                                                 bit last_lp);
      bit               intro_on;
      logic [63:0]      vol;
      logic [63:0]      r;
      logic [31:0]      num32, den32;
      longint           d;
      logic [ACT_W-1:0] act;
      intro_on = intro_armed && cfg_intro != 0;
      vol = UNITY;
      if (!(intro_on || cfg_outro != 0 || rin_t0 != 0 || rout_t0 != 0))
         return UNITY;
      if (ms_now >= rin_t1) begin
         rin_t1 = '0;
         rin_t0 = '0;
      end
      d = longint'({32'd0, tpos}) + longint'({32'd0, cfg_outro})
          - longint'({32'd0, cfg_len});
      if (intro_on && ms_now < cfg_intro) begin
         vol = q16_ratio(64'(ms_now), 64'(cfg_intro), UNITY);
      end else if (cfg_outro != 0 && d > 0 && last_lp) begin
         vol = UNITY - q16_ratio(64'(d), 64'(cfg_outro), UNITY);
      end
      if (rin_t0 != 0 && ms_now < rin_t1) begin
         num32 = ms_now - rin_t0;
         den32 = rin_t1 - rin_t0;
         r = q16_ratio(64'(num32), 64'(den32), 64'h2_0000_0000);
         vol = (vol * r) >> 16;
         if (vol > UNITY)
            vol = UNITY;
      end else if (rout_t0 != 0 && ms_now > rout_t0) begin
         num32 = ms_now - rout_t0;
         den32 = rout_t1 - rout_t0;
         vol = (vol * (UNITY - q16_ratio(64'(num32), 64'(den32), UNITY))) >> 16;
         if (ms_now > rout_t1) begin
            act = pend_act;
            rout_t0 = '0;
            rout_t1 = '0;
            if (act == ACT_PAUSE) begin
               held = 1'b1;
               clear_fade_out();
            end else if (act == ACT_STOP) begin
               held = 1'b1;
               halted = 1'b1;
               clear_fade_out();
               return '0;
            end else begin
               hush = 1'b1;
            end
         end
      end
      return vol;
   endfunction

   function automatic env_out_type envelope_step(logic [OP_W-1:0] op, logic [31:0] ms_now,
                                                 logic [31:0] tpos, logic [15:0] span,
                                                 bit last_lp);
      env_out_type o;
      logic [63:0] vol;
      logic [63:0] g;
      g = '0;
      case (op)
         OP_RESUME: begin
            if (span != 0) begin
               rin_t0 = ms_now;
               rin_t1 = ms_now + 32'(span);
            end
            held = 1'b0;
            halted = 1'b0;
         end
         OP_PAUSE: begin
            if (span == 0) begin
               held = 1'b1;
               clear_fade_out();
            end else begin
               arm_fade_out(ms_now, span, ACT_PAUSE);
            end
         end
         OP_STOP: begin
            if (span == 0) begin
               held = 1'b1;
               halted = 1'b1;
               clear_fade_out();
            end else begin
               arm_fade_out(ms_now, span, ACT_STOP);
            end
         end
         OP_MUTE: begin
            if (span == 0)
               hush = 1'b1;
            else
               arm_fade_out(ms_now, span, ACT_MUTE);
         end
         OP_UNMUTE: hush = 1'b0;
         default: ;
      endcase
      if (!held) begin
         if (!hush) begin
            vol = envelope_gain(ms_now, tpos, last_lp);
            g = (vol * 64'(cfg_master)) >> 16;
            if (g > UNITY)
               g = UNITY;
         end
         if (!halted && intro_armed && cfg_intro != 0 && ms_now > cfg_intro)
            intro_armed = 1'b0;
      end
      if (held)
         g = '0;
      o.gain = g[GAIN_W-1:0];
      o.paused = held;
      o.stopped = halted;
      o.muted = hush || (rout_t0 != 0 && pend_act >= ACT_MUTE);
      return o;
   endfunction

   task automatic report_mismatch(string field, longint unsigned got, longint unsigned exp_v);
      $display("mismatch at result %0d: %s got %0d, wanted %0d", rsp_seen, field, got, exp_v);
      fails++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_intro = '0;
         cfg_outro = '0;
         cfg_len = '0;
         cfg_master = Q_ONE;
         rin_t0 = '0;
         rin_t1 = '0;
         rout_t0 = '0;
         rout_t1 = '0;
         pend_act = ACT_PAUSE;
         hush = 1'b0;
         held = 1'b0;
         halted = 1'b0;
         intro_armed = 1'b1;
         gain_q.delete();
         fails = 0;
         rsp_seen = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_INTRO:  cfg_intro = {16'd0, csr_wdata[15:0]};
               REG_OUTRO:  cfg_outro = {16'd0, csr_wdata[15:0]};
               REG_LENGTH: cfg_len = csr_wdata;
               REG_MASTER: cfg_master = (csr_wdata[16:0] > Q_ONE) ? Q_ONE : csr_wdata[16:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            gain_q.push_back(envelope_step(req_opcode, req_play_time, req_track_time,
                                           req_fade_ms, req_last_loop));
         if (rsp_valid && !rsp_stall) begin
            if (gain_q.size() == 0) begin
               report_mismatch("unexpected item, gain", rsp_gain, 0);
            end else begin
               want = gain_q.pop_front();
               if (rsp_gain !== want.gain)
                  report_mismatch("gain", rsp_gain, want.gain);
               if (rsp_is_paused !== want.paused)
                  report_mismatch("is_paused", rsp_is_paused, want.paused);
               if (rsp_is_stopped !== want.stopped)
                  report_mismatch("is_stopped", rsp_is_stopped, want.stopped);
               if (rsp_is_muted !== want.muted)
                  report_mismatch("is_muted", rsp_is_muted, want.muted);
            end
            rsp_seen++;
         end
      end
      open_count <= gain_q.size();
      fail_count <= fails;
   end

endmodule

// ===== sim/audio_fade_gain_envelope_tb.sv =====
`timescale 1ns / 100ps

module audio_fade_gain_envelope_tb;
   import afg_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int PHASE_ITEMS = 235;
   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [OP_W-1:0]       req_opcode;
   logic [TIME_W-1:0]     req_play_time;
   logic [TIME_W-1:0]     req_track_time;
   logic [MS_W-1:0]       req_fade_ms;
   logic                  req_last_loop;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [GAIN_W-1:0]     rsp_gain;
   logic                  rsp_is_paused;
   logic                  rsp_is_stopped;
   logic                  rsp_is_muted;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    open_count;

   bit          quiet;
   int          idle_cycles = 0;
   logic [31:0] clk_ms;
   logic [31:0] trk_ms;

   audio_fade_gain_envelope DUT (.*);

   afg_gain_checker u_check (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock)
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 16);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic push_item(logic [OP_W-1:0] op, logic [31:0] pt, logic [31:0] tt,
                            logic [15:0] fm, logic ll);
      if (!quiet && $urandom_range(0, 99) < 16) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_play_time <= pt;
      req_track_time <= tt;
      req_fade_ms <= fm;
      req_last_loop <= ll;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic program_regs(logic [31:0] intro, logic [31:0] outro, logic [31:0] len,
                               logic [31:0] master);
      settle();
      write_reg(REG_INTRO, intro);
      write_reg(REG_OUTRO, outro);
      write_reg(REG_LENGTH, len);
      write_reg(REG_MASTER, master);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(logic [15:0] intro, logic [15:0] outro, logic [31:0] len,
                            logic [31:0] master, logic [31:0] cap, bit from_zero,
                            bit calm);
      int               r;
      logic [OP_W-1:0]  op;
      logic [15:0]      fm;
      program_regs(32'(intro), 32'(outro), len, master);
      quiet <= calm;
      if (from_zero)
         clk_ms = '0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         r = $urandom_range(0, 99);
         if (r < 60)
            clk_ms = clk_ms + 1;
         else if (r < 90)
            clk_ms = clk_ms + $urandom_range(0, 25);
         else if (r < 97 || cap != 0)
            clk_ms = clk_ms + $urandom_range(0, 3000);
         else if (r < 99)
            clk_ms = $urandom;
         else
            clk_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
         if (cap != 0 && clk_ms > cap)
            clk_ms = $urandom_range(0, 2000);

         r = $urandom_range(0, 99);
         if (r < 60)
            trk_ms = len - $urandom_range(0, outro + 20) + $urandom_range(0, 20);
         else if (r < 85)
            trk_ms = $urandom_range(0, 2000);
         else
            trk_ms = $urandom;

         r = $urandom_range(0, 99);
         if (r < 62)      op = OP_TICK;
         else if (r < 72) op = OP_RESUME;
         else if (r < 79) op = OP_PAUSE;
         else if (r < 85) op = OP_STOP;
         else if (r < 92) op = OP_MUTE;
         else if (r < 98) op = OP_UNMUTE;
         else             op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;

         r = $urandom_range(0, 99);
         if (r < 25)      fm = '0;
         else if (r < 75) fm = 16'($urandom_range(1, 40));
         else if (r < 93) fm = 16'($urandom_range(41, 2000));
         else if (r < 97) fm = 16'($urandom_range(0, 65535));
         else             fm = 16'hFFFF;

         push_item(op, clk_ms, trk_ms, fm, $urandom_range(0, 99) < 70);
      end
   endtask

   initial begin
      reset = 1'b1;
      quiet = 1'b0;
      req_valid = 1'b0;
      req_opcode = OP_TICK;
      req_play_time = '0;
      req_track_time = '0;
      req_fade_ms = '0;
      req_last_loop = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = REG_INTRO;
      csr_wdata = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // intro at full length, master above full scale
      program_regs(32'd65535, 32'd65535, 32'd1000, 32'h1FFFF);
      push_item(OP_TICK, 32'd0, 32'd999, 16'd0, 1'b1);
      push_item(OP_TICK, 32'd1000, 32'd999, 16'd0, 1'b1);
      push_item(OP_RESUME, 32'd0, 32'd0, 16'd10, 1'b0);   // ramp at time zero stays idle
      push_item(OP_RESUME, 32'd100, 32'd0, 16'd50, 1'b0);
      push_item(OP_TICK, 32'd120, 32'd0, 16'd0, 1'b0);
      push_item(OP_TICK, 32'd160, 32'd0, 16'd0, 1'b0);
      push_item(OP_PAUSE, 32'd200, 32'd0, 16'd20, 1'b0);
      push_item(OP_TICK, 32'd210, 32'd0, 16'd0, 1'b0);
      push_item(OP_TICK, 32'd221, 32'd0, 16'd0, 1'b0);
      push_item(OP_TICK, 32'd230, 32'd0, 16'd0, 1'b0);
      push_item(OP_RESUME, 32'd240, 32'd0, 16'd0, 1'b0);
      push_item(OP_STOP, 32'd250, 32'd0, 16'd0, 1'b0);
      push_item(OP_RESUME, 32'd260, 32'd0, 16'hFFFF, 1'b0);
      push_item(OP_MUTE, 32'd270, 32'd0, 16'd0, 1'b0);
      push_item(OP_UNMUTE, 32'd280, 32'd0, 16'd77, 1'b0);
      push_item(OP_MUTE, 32'd290, 32'd0, 16'd5, 1'b0);
      push_item(OP_TICK, 32'd296, 32'd0, 16'd0, 1'b0);
      push_item(OP_UNMUTE, 32'd300, 32'd0, 16'd0, 1'b0);
      push_item(OP_STOP, 32'd310, 32'd0, 16'd3, 1'b0);
      push_item(OP_TICK, 32'd314, 32'd0, 16'd0, 1'b0);
      push_item(OP_SPARE_A, 32'd320, 32'd0, 16'd9, 1'b1);
      push_item(OP_SPARE_B, 32'd330, 32'd0, 16'd9, 1'b1);
      push_item(OP_RESUME, 32'd340, 32'd0, 16'd0, 1'b0);
      clk_ms = 32'd340;

      run_phase(16'd65535, 16'd0, 32'd0, 32'd65536, 32'd60000, 1'b0, 1'b0);
      run_phase(16'd0, 16'd500, 32'd20000, 32'd40000, 32'd0, 1'b0, 1'b0);
      run_phase(16'd300, 16'd100, 32'd150, 32'd65535, 32'd0, 1'b1, 1'b0);
      run_phase(16'd0, 16'd65535, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0, 1'b1);
      run_phase(16'd40, 16'd1, 32'd5000, 32'd12345, 32'd0, 1'b0, 1'b0);
      run_phase(16'd65535, 16'd2000, 32'd1000, 32'd65536, 32'd0, 1'b0, 1'b0);
      run_phase(16'd0, 16'd0, 32'd0, 32'h0001_0001, 32'd0, 1'b0, 1'b0);
      run_phase(16'd1, 16'd30, 32'd300, 32'd65536, 32'd0, 1'b0, 1'b0);

      settle();
      if (fail_count == 0 && open_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/afg_pkg.sv
rtl/core/afg_div.sv
rtl/core/afg_mul.sv
rtl/core/audio_fade_gain_envelope.sv
sim/afg_gain_checker.sv
sim/audio_fade_gain_envelope_tb.sv
